/* rtl/core/wcp_pkg.sv */
// Shared types and constants for the WAV chunk header parser.
// Holds chunk tags, result status codes, the sample type mapping and
// the command/status structs between controller and datapath.
package wcp_pkg;

	// Chunk tags as read little-endian into a 32-bit word
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_RF64 = 32'h3436_4652;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_DS64 = 32'h3436_7364;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [31:0] LEN_ALL_ONES = 32'hFFFF_FFFF;

	// Result status codes
	localparam logic [1:0] STAT_HEADER  = 2'd0;
	localparam logic [1:0] STAT_FOUND   = 2'd1;
	localparam logic [1:0] STAT_PAYLOAD = 2'd2;
	localparam logic [1:0] STAT_ERROR   = 2'd3;

	// Format codes
	localparam logic [15:0] FMT_PCM   = 16'd1;
	localparam logic [15:0] FMT_FLOAT = 16'd3;

	// Sample type codes
	localparam logic [2:0] STYPE_NONE = 3'd0;
	localparam logic [2:0] STYPE_I8   = 3'd1;
	localparam logic [2:0] STYPE_I16  = 3'd2;
	localparam logic [2:0] STYPE_I24  = 3'd3;
	localparam logic [2:0] STYPE_I32  = 3'd4;
	localparam logic [2:0] STYPE_I64  = 3'd5;
	localparam logic [2:0] STYPE_F32  = 3'd6;
	localparam logic [2:0] STYPE_F64  = 3'd7;

	// Controller to datapath
	typedef struct packed {
		logic step;
	} wcp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic needs_div;
		logic div_done;
	} wcp_stat_t;

	// Map format code and bit depth to a sample type code
	function automatic logic [2:0] sample_type_of(input logic [15:0] fmt,
		input logic [15:0] bits);
		logic [2:0] t;
		t = STYPE_NONE;
		if (fmt == FMT_PCM) begin
			case (bits)
				16'd8:   t = STYPE_I8;
				16'd16:  t = STYPE_I16;
				16'd24:  t = STYPE_I24;
				16'd32:  t = STYPE_I32;
				16'd64:  t = STYPE_I64;
				default: t = STYPE_NONE;
			endcase
		end else if (fmt == FMT_FLOAT) begin
			case (bits)
				16'd32:  t = STYPE_F32;
				16'd64:  t = STYPE_F64;
				default: t = STYPE_NONE;
			endcase
		end
		return t;
	endfunction

	// Replace one byte of a 32-bit word
	function automatic logic [31:0] put_byte32(input logic [31:0] word,
		input logic [1:0] pos, input logic [7:0] b);
		logic [31:0] w;
		w = word;
		w[pos*8 +: 8] = b;
		return w;
	endfunction

endpackage

/* rtl/core/wcp_div.sv */
// Iterative 16-bit unsigned divider, one quotient bit per cycle.
// Standalone; used by the parser datapath for bytes per sample.
module wcp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic [15:0] quotient,
	output logic        done
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] den_q;
	logic [16:0] r_sh;
	logic [16:0] r_sub;
	logic        fits;

	// Shift in the next dividend bit and trial-subtract
	always_comb begin
		r_sh  = {rem_q, quo_q[15]};
		r_sub = r_sh - {1'b0, den_q};
		fits  = (r_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load operands, then advance one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? r_sub[15:0] : r_sh[15:0];
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

/* rtl/core/wcp_dp.sv */
// Datapath of the WAV chunk header parser: chunk walk, field capture,
// result registers. Depends on wcp_pkg and wcp_div.
module wcp_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  wcp_pkg::wcp_cmd_t  cmd,
	input  logic [7:0]         in_byte,
	output wcp_pkg::wcp_stat_t stat,
	output logic [1:0]         status,
	output logic [7:0]         payload_byte,
	output logic [15:0]        channels,
	output logic [31:0]        sample_rate,
	output logic [15:0]        bytes_per_frame,
	output logic [15:0]        bytes_per_sample,
	output logic [2:0]         sample_type,
	output logic [63:0]        data_size
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_WAVEID = 3'd1;
	localparam logic [2:0] PH_DS64   = 3'd2;
	localparam logic [2:0] PH_FMT    = 3'd3;
	localparam logic [2:0] PH_SKIP   = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_ERROR  = 3'd6;

	logic [2:0]  phase_q, phase_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] len_q, len_d;
	logic [32:0] cnt_q, cnt_d;
	logic [23:0] wave_q, wave_d;
	logic [63:0] ds64_q, ds64_d;
	logic [15:0] fmt_q, fmt_d;
	logic [15:0] bits_q, bits_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] align_q, align_d;
	logic [15:0] spb_q;
	logic [2:0]  type_q, type_d;
	logic [63:0] dlen_q, dlen_d;
	logic [1:0]  status_q, status_d;
	logic [7:0]  payload_q, payload_d;

	logic [4:0]  idx;
	logic [31:0] len_full;
	logic        do_skip;
	logic [32:0] skip_n;
	logic        needs_div;
	logic        div_start;
	logic [15:0] quo;
	logic        div_done;

	assign idx      = cnt_q[4:0];
	assign len_full = {in_byte, len_q[23:0]};
	assign needs_div = (phase_q == PH_FMT) && (idx == 5'd15);
	assign div_start = cmd.step && needs_div;

	// Next-state logic for one accepted byte
	always_comb begin
		phase_d   = phase_q;
		tag_d     = tag_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		wave_d    = wave_q;
		ds64_d    = ds64_q;
		fmt_d     = fmt_q;
		bits_d    = bits_q;
		chan_d    = chan_q;
		rate_d    = rate_q;
		align_d   = align_q;
		type_d    = type_q;
		dlen_d    = dlen_q;
		status_d  = wcp_pkg::STAT_HEADER;
		payload_d = 8'd0;
		do_skip   = 1'b0;
		skip_n    = '0;
		case (phase_q)
			PH_HEADER: begin
				if (!idx[2]) begin
					tag_d = wcp_pkg::put_byte32(tag_q, idx[1:0], in_byte);
				end else begin
					len_d = wcp_pkg::put_byte32(len_q, idx[1:0], in_byte);
				end
				if (idx >= 5'd7) begin
					// Dispatch on the completed tag
					cnt_d = '0;
					if (tag_q == wcp_pkg::TAG_RIFF || tag_q == wcp_pkg::TAG_RF64) begin
						phase_d = PH_WAVEID;
					end else if (tag_q == wcp_pkg::TAG_DS64) begin
						phase_d = PH_DS64;
					end else if (tag_q == wcp_pkg::TAG_FMT) begin
						phase_d = PH_FMT;
					end else if (tag_q == wcp_pkg::TAG_DATA) begin
						dlen_d   = (len_full == wcp_pkg::LEN_ALL_ONES) ? ds64_q
							: {32'd0, len_full};
						phase_d  = PH_DATA;
						status_d = wcp_pkg::STAT_FOUND;
					end else begin
						do_skip = 1'b1;
						skip_n  = {1'b0, len_full} + {32'd0, len_full[0]};
					end
				end else begin
					cnt_d = cnt_q + 33'd1;
				end
			end
			PH_WAVEID: begin
				if (idx >= 5'd3) begin
					if ({in_byte, wave_q} != wcp_pkg::TAG_WAVE) begin
						phase_d  = PH_ERROR;
						status_d = wcp_pkg::STAT_ERROR;
					end else begin
						do_skip = 1'b1;
						skip_n  = {32'd0, len_q[0]};
					end
				end else begin
					case (idx[1:0])
						2'd0:    wave_d[7:0]   = in_byte;
						2'd1:    wave_d[15:8]  = in_byte;
						default: wave_d[23:16] = in_byte;
					endcase
					cnt_d = cnt_q + 33'd1;
				end
			end
			PH_DS64: begin
				if (idx >= 5'd8 && idx < 5'd16) begin
					ds64_d[idx[2:0]*8 +: 8] = in_byte;
				end
				if (idx >= 5'd23) begin
					do_skip = 1'b1;
					skip_n  = {1'b0, (len_q >= 32'd24) ? (len_q - 32'd24) : 32'd0}
						+ {32'd0, len_q[0]};
				end else begin
					cnt_d = cnt_q + 33'd1;
				end
			end
			PH_FMT: begin
				if (idx < 5'd2) begin
					fmt_d[idx[0]*8 +: 8] = in_byte;
				end else if (idx < 5'd4) begin
					chan_d[idx[0]*8 +: 8] = in_byte;
				end else if (idx < 5'd8) begin
					rate_d = wcp_pkg::put_byte32(rate_q, idx[1:0], in_byte);
				end else if (idx >= 5'd12 && idx < 5'd14) begin
					align_d[idx[0]*8 +: 8] = in_byte;
				end else if (idx >= 5'd14) begin
					bits_d[idx[0]*8 +: 8] = in_byte;
				end
				if (idx >= 5'd15) begin
					type_d  = wcp_pkg::sample_type_of(fmt_q, bits_d);
					do_skip = 1'b1;
					skip_n  = {1'b0, (len_q >= 32'd16) ? (len_q - 32'd16) : 32'd0}
						+ {32'd0, len_q[0]};
				end else begin
					cnt_d = cnt_q + 33'd1;
				end
			end
			PH_SKIP: begin
				if (cnt_q <= 33'd1) begin
					phase_d = PH_HEADER;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q - 33'd1;
				end
			end
			PH_DATA: begin
				status_d  = wcp_pkg::STAT_PAYLOAD;
				payload_d = in_byte;
			end
			default: begin
				phase_d  = PH_ERROR;
				status_d = wcp_pkg::STAT_ERROR;
			end
		endcase
		// Start a skip, or go straight back to header on zero
		if (do_skip) begin
			if (skip_n == 33'd0) begin
				phase_d = PH_HEADER;
				cnt_d   = '0;
			end else begin
				phase_d = PH_SKIP;
				cnt_d   = skip_n;
			end
		end
	end

	// Bytes per sample: block align over channels
	wcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (align_q),
		.divisor  (chan_q),
		.quotient (quo),
		.done     (div_done)
	);

	// Commit state per accepted beat, bytes per sample on divide done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			tag_q     <= '0;
			len_q     <= '0;
			cnt_q     <= '0;
			wave_q    <= '0;
			ds64_q    <= '0;
			fmt_q     <= '0;
			bits_q    <= '0;
			chan_q    <= '0;
			rate_q    <= '0;
			align_q   <= '0;
			spb_q     <= '0;
			type_q    <= '0;
			dlen_q    <= '0;
			status_q  <= '0;
			payload_q <= '0;
		end else begin
			if (cmd.step) begin
				phase_q   <= phase_d;
				tag_q     <= tag_d;
				len_q     <= len_d;
				cnt_q     <= cnt_d;
				wave_q    <= wave_d;
				ds64_q    <= ds64_d;
				fmt_q     <= fmt_d;
				bits_q    <= bits_d;
				chan_q    <= chan_d;
				rate_q    <= rate_d;
				align_q   <= align_d;
				type_q    <= type_d;
				dlen_q    <= dlen_d;
				status_q  <= status_d;
				payload_q <= payload_d;
			end
			if (div_done) begin
				spb_q <= (chan_q == 16'd0) ? 16'd0 : quo;
			end
		end
	end

	assign stat.needs_div   = needs_div;
	assign stat.div_done    = div_done;
	assign status           = status_q;
	assign payload_byte     = payload_q;
	assign channels         = chan_q;
	assign sample_rate      = rate_q;
	assign bytes_per_frame  = align_q;
	assign bytes_per_sample = spb_q;
	assign sample_type      = type_q;
	assign data_size        = dlen_q;

endmodule

/* rtl/core/wcp_ctrl.sv */
// Controller of the WAV chunk header parser: handshakes and divide wait.
// Depends on wcp_pkg.
module wcp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  wcp_pkg::wcp_stat_t stat,
	output wcp_pkg::wcp_cmd_t  cmd,
	output logic               dividing
);

	localparam logic ST_RUN = 1'b0;
	localparam logic ST_DIV = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic accept;

	// Take a beat when not dividing and the result slot is free or draining
	assign in_ready = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (accept) begin
						if (stat.needs_div) begin
							state_q     <= ST_DIV;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end else if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_DIV: begin
					// Hold the result until bytes per sample lands
					if (stat.div_done) begin
						state_q     <= ST_RUN;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q     <= ST_RUN;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.step  = accept;
	assign out_valid = out_valid_q;
	assign dividing  = (state_q == ST_DIV);

endmodule

/* rtl/core/wav_chunk_header_parser_unit.sv */
// WAV/RF64 chunk header parser: one input byte beat gives one result beat.
// The result is registered the cycle after accept; on the last byte of a
// fmt chunk it waits for the bit-serial block-align/channels divider.
// Throughput 1 byte per cycle otherwise, with the result register drained.
// Asynchronous active-low reset returns to the chunk header walk, all
// format fields and sizes zero, no result pending.
module wav_chunk_header_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  payload_byte,
	output logic [15:0] channels,
	output logic [31:0] sample_rate,
	output logic [15:0] bytes_per_frame,
	output logic [15:0] bytes_per_sample,
	output logic [2:0]  sample_type,
	output logic [63:0] data_size
);

	wcp_pkg::wcp_cmd_t  cmd;
	wcp_pkg::wcp_stat_t stat;
	logic               dividing;

	wcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd),
		.dividing  (dividing)
	);

	wcp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.in_byte          (in_byte),
		.stat             (stat),
		.status           (status),
		.payload_byte     (payload_byte),
		.channels         (channels),
		.sample_rate      (sample_rate),
		.bytes_per_frame  (bytes_per_frame),
		.bytes_per_sample (bytes_per_sample),
		.sample_type      (sample_type),
		.data_size        (data_size)
	);

`ifndef SYNTHESIS
	// An accepted beat yields a result next cycle or enters the divide wait
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (out_valid || dividing))
		else $error("accepted beat produced neither result nor divide");

	// No beat is taken and no result shown while dividing
	a_div_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		dividing |-> (!in_ready && !out_valid))
		else $error("handshake active during divide");

	// Payload byte is zero unless the result is a payload beat
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != wcp_pkg::STAT_PAYLOAD) |-> (payload_byte == 8'd0))
		else $error("payload byte set on non-payload result");
`endif

endmodule
